@@ src/cdd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Central difference derivative package
// Shared widths and register index codes for the derivative block.
// ----------------------------------------------------------------------------
package cdd_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int FRAC_BITS    = 16;

   // Differences of two samples or positions need one bit more.
   localparam int DIFF_W = SAMPLE_WIDTH + 1;
   // Scaled numerator, remainder and step counter of the divider.
   localparam int NUM_W  = DIFF_W + FRAC_BITS;
   localparam int REM_W  = DIFF_W + 1;
   localparam int CNT_W  = $clog2(NUM_W);

   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UNIFORM_MODE = 1'b0,
      CSR_AXIS_STEP    = 1'b1
   } csr_index_type;

   localparam logic signed [SAMPLE_WIDTH-1:0] AXIS_STEP_RESET =
      SAMPLE_WIDTH'(1 << FRAC_BITS);

endpackage

@@ src/cdd_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Derivative request channel
// Valid/ready channel that carries one point of a series per item.
// ----------------------------------------------------------------------------
interface cdd_req_if;

   logic                                    valid;
   logic                                    ready;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0] sample;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0] position;
   logic                                    last_point;

   modport source (output valid, output sample, output position, output last_point,
                   input ready);
   modport sink (input valid, input sample, input position, input last_point,
                 output ready);

endinterface

@@ src/cdd_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Derivative response channel
// Valid/ready channel that carries one derivative with its status flags.
// ----------------------------------------------------------------------------
interface cdd_rsp_if;

   logic                                    valid;
   logic                                    ready;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0] slope;
   logic                                    zero_divide;
   logic                                    saturated;
   logic                                    too_short;
   logic                                    series_end;

   modport source (output valid, output slope, output zero_divide, output saturated,
                   output too_short, output series_end, input ready);
   modport sink (input valid, input slope, input zero_divide, input saturated,
                 input too_short, input series_end, output ready);

endinterface

@@ src/central_difference_derivative.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Central difference derivative
// Streaming derivative of a sampled curve in signed Q16.16.
//
// Each req item is one point of a series, the final point marked by
// last_point. Interior points get the central difference, the first point
// the forward and the final point the backward difference. A derivative
// leaves on rsp once its right-hand neighbor has arrived, so one item gives
// zero, one or two rsp items. The csr port selects uniform mode and the
// constant axis step; write it only while the block is idle.
// The first point of a series is only stored unless it also ends it.
// Every derivative runs through one shared radix-2 restoring divider of 49
// steps; req.ready stays low while a later point is worked on, and the final
// point runs the divider twice. A zero denominator skips the divider.
// Results pass through an output register: the next item is accepted while
// a result waits there, and a stalled rsp side only holds the block once a
// second result is ready. Synchronous reset empties the series, clears the
// output register and restores uniform_mode to 0 and axis_step to 1.0.
// ----------------------------------------------------------------------------
module central_difference_derivative (
   input  logic                                 clock,
   input  logic                                 reset,
   cdd_req_if.sink                              req,
   cdd_rsp_if.source                            rsp,
   input  logic                                 csr_write_enable,
   input  logic [cdd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cdd_pkg::SAMPLE_WIDTH-1:0]     csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_DIV,
      S_FIN,
      S_EMIT
   } state_type;

   state_type                                  state_ff;

   logic                                       uniform_mode_ff;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0]    axis_step_ff;

   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0]    older_sample_ff;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0]    newer_sample_ff;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0]    older_position_ff;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0]    newer_position_ff;
   logic [1:0]                                 points_seen_ff;

   logic signed [cdd_pkg::DIFF_W-1:0]          dy_ff;
   logic signed [cdd_pkg::DIFF_W-1:0]          dx_ff;
   logic signed [cdd_pkg::DIFF_W-1:0]          dyb_ff;
   logic signed [cdd_pkg::DIFF_W-1:0]          dxb_ff;
   logic                                       have_b_ff;
   logic                                       end_ff;

   logic                                       neg_ff;
   logic [cdd_pkg::DIFF_W-1:0]                 d_ff;
   logic [cdd_pkg::NUM_W-1:0]                  num_ff;
   logic [cdd_pkg::REM_W-1:0]                  rem_ff;
   logic [cdd_pkg::SAMPLE_WIDTH-1:0]           q_ff;
   logic                                       ovf_ff;
   logic [cdd_pkg::CNT_W-1:0]                  cnt_ff;

   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0]    res_slope_ff;
   logic                                       res_zero_divide_ff;
   logic                                       res_saturated_ff;
   logic                                       res_too_short_ff;
   logic                                       res_series_end_ff;

   logic                                       rsp_valid_ff;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0]    rsp_slope_ff;
   logic                                       rsp_zero_divide_ff;
   logic                                       rsp_saturated_ff;
   logic                                       rsp_too_short_ff;
   logic                                       rsp_series_end_ff;

   logic                                       accept;
   logic                                       out_free;
   logic signed [cdd_pkg::DIFF_W-1:0]          dy_one_in;
   logic signed [cdd_pkg::DIFF_W-1:0]          dy_cen_in;
   logic signed [cdd_pkg::DIFF_W-1:0]          dx_one_in;
   logic signed [cdd_pkg::DIFF_W-1:0]          dx_cen_in;
   logic [cdd_pkg::DIFF_W-1:0]                 dy_mag_in;
   logic [cdd_pkg::DIFF_W-1:0]                 dx_mag_in;
   logic [cdd_pkg::REM_W-1:0]                  rem_shift;
   logic                                       quot_bit;
   logic [cdd_pkg::REM_W-1:0]                  rem_in;
   logic [cdd_pkg::SAMPLE_WIDTH-1:0]           lim;
   logic                                       sat_in;
   logic [cdd_pkg::SAMPLE_WIDTH-1:0]           mag;
   logic signed [cdd_pkg::SAMPLE_WIDTH-1:0]    slope_in;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.slope       = rsp_slope_ff;
   assign rsp.zero_divide = rsp_zero_divide_ff;
   assign rsp.saturated   = rsp_saturated_ff;
   assign rsp.too_short   = rsp_too_short_ff;
   assign rsp.series_end  = rsp_series_end_ff;

   // Differences of the new point against the two previous points.
   always_comb begin
      dy_one_in = cdd_pkg::DIFF_W'(req.sample) - cdd_pkg::DIFF_W'(newer_sample_ff);
      dy_cen_in = cdd_pkg::DIFF_W'(req.sample) - cdd_pkg::DIFF_W'(older_sample_ff);
      if (uniform_mode_ff) begin
         dx_one_in = cdd_pkg::DIFF_W'(axis_step_ff);
         dx_cen_in = $signed({axis_step_ff, 1'b0});
      end else begin
         dx_one_in = cdd_pkg::DIFF_W'(req.position) - cdd_pkg::DIFF_W'(newer_position_ff);
         dx_cen_in = cdd_pkg::DIFF_W'(req.position) - cdd_pkg::DIFF_W'(older_position_ff);
      end
   end

   assign dy_mag_in = dy_ff[cdd_pkg::DIFF_W-1] ? cdd_pkg::DIFF_W'(-dy_ff)
                                               : cdd_pkg::DIFF_W'(dy_ff);
   assign dx_mag_in = dx_ff[cdd_pkg::DIFF_W-1] ? cdd_pkg::DIFF_W'(-dx_ff)
                                               : cdd_pkg::DIFF_W'(dx_ff);

   // One restoring division step.
   always_comb begin
      rem_shift = {rem_ff[cdd_pkg::REM_W-2:0], num_ff[cdd_pkg::NUM_W-1]};
      quot_bit  = (rem_shift >= cdd_pkg::REM_W'(d_ff));
      rem_in    = quot_bit ? rem_shift - cdd_pkg::REM_W'(d_ff) : rem_shift;
   end

   // Saturation and sign of the finished quotient.
   always_comb begin
      lim      = (cdd_pkg::SAMPLE_WIDTH'(1) << (cdd_pkg::SAMPLE_WIDTH - 1))
                 - cdd_pkg::SAMPLE_WIDTH'(!neg_ff);
      sat_in   = ovf_ff || (q_ff > lim);
      mag      = sat_in ? lim : q_ff;
      slope_in = neg_ff ? $signed(-mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uniform_mode_ff <= 1'b0;
         axis_step_ff    <= cdd_pkg::AXIS_STEP_RESET;
      end else if (csr_write_enable) begin
         case (cdd_pkg::csr_index_type'(csr_index))
            cdd_pkg::CSR_UNIFORM_MODE: uniform_mode_ff <= csr_write_data[0];
            cdd_pkg::CSR_AXIS_STEP:    axis_step_ff    <= $signed(csr_write_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         points_seen_ff <= 2'd0;
         have_b_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (points_seen_ff == 2'd0) begin
                     newer_sample_ff   <= req.sample;
                     newer_position_ff <= req.position;
                     if (req.last_point) begin
                        res_slope_ff       <= '0;
                        res_zero_divide_ff <= 1'b0;
                        res_saturated_ff   <= 1'b0;
                        res_too_short_ff   <= 1'b1;
                        res_series_end_ff  <= 1'b1;
                        have_b_ff          <= 1'b0;
                        state_ff           <= S_EMIT;
                     end else begin
                        points_seen_ff <= 2'd1;
                     end
                  end else begin
                     if (points_seen_ff == 2'd1) begin
                        dy_ff <= dy_one_in;
                        dx_ff <= dx_one_in;
                     end else begin
                        dy_ff <= dy_cen_in;
                        dx_ff <= dx_cen_in;
                     end
                     dyb_ff    <= dy_one_in;
                     dxb_ff    <= dx_one_in;
                     have_b_ff <= req.last_point;
                     end_ff    <= 1'b0;
                     state_ff  <= S_LOAD;
                     if (req.last_point) begin
                        points_seen_ff <= 2'd0;
                     end else begin
                        older_sample_ff   <= newer_sample_ff;
                        older_position_ff <= newer_position_ff;
                        newer_sample_ff   <= req.sample;
                        newer_position_ff <= req.position;
                        points_seen_ff    <= 2'd2;
                     end
                  end
               end
            end
            S_LOAD: begin
               neg_ff <= dy_ff[cdd_pkg::DIFF_W-1] ^ dx_ff[cdd_pkg::DIFF_W-1];
               d_ff   <= dx_mag_in;
               num_ff <= {dy_mag_in, {cdd_pkg::FRAC_BITS{1'b0}}};
               rem_ff <= '0;
               q_ff   <= '0;
               ovf_ff <= 1'b0;
               cnt_ff <= cdd_pkg::CNT_W'(cdd_pkg::NUM_W - 1);
               if (dx_ff == '0) begin
                  res_slope_ff       <= '0;
                  res_zero_divide_ff <= 1'b1;
                  res_saturated_ff   <= 1'b0;
                  res_too_short_ff   <= 1'b0;
                  res_series_end_ff  <= end_ff;
                  state_ff           <= S_EMIT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               num_ff <= {num_ff[cdd_pkg::NUM_W-2:0], 1'b0};
               rem_ff <= rem_in;
               q_ff   <= {q_ff[cdd_pkg::SAMPLE_WIDTH-2:0], quot_bit};
               ovf_ff <= ovf_ff | q_ff[cdd_pkg::SAMPLE_WIDTH-1];
               cnt_ff <= cnt_ff - cdd_pkg::CNT_W'(1);
               if (cnt_ff == '0) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               res_slope_ff       <= slope_in;
               res_zero_divide_ff <= 1'b0;
               res_saturated_ff   <= sat_in;
               res_too_short_ff   <= 1'b0;
               res_series_end_ff  <= end_ff;
               state_ff           <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_slope_ff       <= res_slope_ff;
                  rsp_zero_divide_ff <= res_zero_divide_ff;
                  rsp_saturated_ff   <= res_saturated_ff;
                  rsp_too_short_ff   <= res_too_short_ff;
                  rsp_series_end_ff  <= res_series_end_ff;
                  if (have_b_ff) begin
                     dy_ff     <= dyb_ff;
                     dx_ff     <= dxb_ff;
                     end_ff    <= 1'b1;
                     have_b_ff <= 1'b0;
                     state_ff  <= S_LOAD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // An item that starts a derivative or ends a one-point series leaves the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (points_seen_ff != 2'd0 || req.last_point)) |=> !req.ready)
      else $error("req.ready high right after an item that needs work");

   // The divider counts down one step per cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff != '0) |=>
         (state_ff == S_DIV && cnt_ff == $past(cnt_ff) - cdd_pkg::CNT_W'(1)))
      else $error("divider step count out of sequence");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == '0) |=> state_ff == S_FIN)
      else $error("divider did not finish after its last step");

   // A result appears on rsp only when the sequencer hands one over.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EMIT && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("rsp.valid rose without a finished result");

endmodule
